@@ src/qswg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qswg_pkg
// shared constants, register map and arithmetic helpers for the quantizer
// step and frequency weight generator
// ----------------------------------------------------------------------------
package qswg_pkg;

    // block geometry default
    localparam int unsigned BlockEdgeDefault = 16;

    // field widths
    localparam int unsigned SlopeW  = 16;
    localparam int unsigned BlendW  = 16;
    localparam int unsigned GainW   = 16;
    localparam int unsigned WeightW = 16;
    localparam int unsigned StepW   = 20;
    localparam int unsigned ScaleW  = 16;
    localparam int unsigned ModeW   = 2;
    localparam int unsigned RootW   = 17;

    // configuration port
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 20;

    localparam logic [CfgAddrW-1:0] CfgWeightMode = 3'd0;
    localparam logic [CfgAddrW-1:0] CfgSlope      = 3'd1;
    localparam logic [CfgAddrW-1:0] CfgBlend      = 3'd2;
    localparam logic [CfgAddrW-1:0] CfgBaseStep   = 3'd3;
    localparam logic [CfgAddrW-1:0] CfgBlockScale = 3'd4;

    // weight modes
    localparam logic [ModeW-1:0] ModeLinear    = 2'd0;
    localparam logic [ModeW-1:0] ModeRadial    = 2'd1;
    localparam logic [ModeW-1:0] ModeSeparable = 2'd2;
    localparam logic [ModeW-1:0] ModeEnergy    = 2'd3;

    // reset values
    localparam logic [ModeW-1:0]  ModeReset  = ModeLinear;
    localparam logic [SlopeW-1:0] SlopeReset = 16'd19661;
    localparam logic [BlendW-1:0] BlendReset = 16'd0;
    localparam logic [StepW-1:0]  BaseReset  = 20'd256;
    localparam logic [ScaleW-1:0] ScaleReset = 16'd4096;

    // fixed point limits
    localparam int unsigned OneQ15      = 32768;
    localparam int unsigned HalfQ15     = 16384;
    localparam int unsigned WeightFloor = 1638;
    localparam int unsigned WeightCeil  = 65535;
    localparam int unsigned StepFloor   = 128;
    localparam int unsigned StepCeil    = 1048575;
    localparam int unsigned StepShift   = 27;

    // signed divide by 2^15, rounding half away from zero
    function automatic logic signed [47:0] rdiv_q15(input logic signed [47:0] num);
        logic signed [47:0] mag;
        logic signed [47:0] res;
        if (num >= 48'sd0)
        begin
            res = (num + 48'sd16384) >>> 15;
        end
        else
        begin
            mag = -num;
            res = -((mag + 48'sd16384) >>> 15);
        end
        return res;
    endfunction

    // q1.15 root of s / (3*maxf^2): largest r with r^2 * 3*maxf^2 <= s * 2^30
    function automatic logic [RootW-1:0] root_entry(input int unsigned s,
                                                    input int unsigned maxf);
        longint unsigned den;
        longint unsigned lim;
        longint unsigned cand;
        logic [RootW-1:0] r;
        den = 64'(3 * maxf * maxf);
        lim = 64'(s) << 30;
        r   = '0;
        for (int b = RootW - 1; b >= 0; b--)
        begin
            cand = 64'(r | (RootW'(1) << b));
            if (cand * cand * den <= lim)
            begin
                r = r | (RootW'(1) << b);
            end
        end
        return r;
    endfunction

endpackage

@@ src/quant_step_weight_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quant_step_weight_generator_core
// frequency weight and quantizer step for one coefficient position of a
// cubic transform block, in a nine stage pipeline
// ----------------------------------------------------------------------------
// One coefficient position enters per clock while s_tready is high; its weight
// and step leave stage nine. Every stage holds its own valid bit and only stalls when
// the stage after it is full and blocked, so empty slots are squeezed out and
// an output stall backs up into the input only once the whole pipe is full.
// The radial root is a constant table of 3*(2^coord_bits-1)^2+1 entries read
// into a register. The step product is split into two 18-bit partial
// products. Configuration writes belong in idle periods with the pipe drained.
module quant_step_weight_generator_core #(
    parameter int unsigned BLOCK_EDGE = qswg_pkg::BlockEdgeDefault,
    localparam int unsigned CoordW = (BLOCK_EDGE > 2) ? $clog2(BLOCK_EDGE) : 1,
    localparam int unsigned SDataW = ((3 * CoordW + qswg_pkg::GainW + 7) / 8) * 8,
    localparam int unsigned MDataW =
        ((qswg_pkg::WeightW + qswg_pkg::StepW + 7) / 8) * 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [qswg_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [qswg_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [SDataW-1:0]             s_tdata,   // coord_x, coord_y, coord_z, energy_gain
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [MDataW-1:0]             m_tdata    // weight, step_size
);

    localparam int unsigned NumStages = 9;
    localparam int unsigned MaxFreq   = BLOCK_EDGE - 1;
    localparam int unsigned CoordMax  = (1 << CoordW) - 1;
    localparam int unsigned SumW      = $clog2(3 * CoordMax + 1);
    localparam int unsigned SqMax     = 3 * CoordMax * CoordMax;
    localparam int unsigned SqW       = $clog2(SqMax + 1);
    localparam int unsigned QuotW     = 17;

    localparam int unsigned LinDen    = 3 * MaxFreq;
    localparam int unsigned AxDen     = MaxFreq;
    localparam int unsigned LinNumW   = qswg_pkg::SlopeW + SumW + 1;
    localparam int unsigned AxNumW    = qswg_pkg::SlopeW + CoordW + 1;
    localparam int unsigned LinShift  = LinNumW + $clog2(LinDen);
    localparam int unsigned AxShift   = AxNumW + $clog2(AxDen);
    localparam int unsigned LinRecipW = LinNumW + 1;
    localparam int unsigned AxRecipW  = AxNumW + 1;
    localparam longint unsigned LinRecip = ((64'd1 << LinShift) / LinDen) + 64'd1;
    localparam longint unsigned AxRecip  = ((64'd1 << AxShift) / AxDen) + 64'd1;
    localparam int unsigned LinProdW  = LinNumW + LinRecipW;
    localparam int unsigned AxProdW   = AxNumW + AxRecipW;

    // configuration registers
    logic [qswg_pkg::ModeW-1:0]  mode_reg;
    logic [qswg_pkg::SlopeW-1:0] slope_reg;
    logic [qswg_pkg::BlendW-1:0] blend_reg;
    logic [qswg_pkg::StepW-1:0]  base_reg;
    logic [qswg_pkg::ScaleW-1:0] scale_reg;

    // handshake
    logic [NumStages:1]   valid_reg;
    logic [NumStages+1:1] rdy;

    // input fields
    logic [CoordW-1:0]          in_x;
    logic [CoordW-1:0]          in_y;
    logic [CoordW-1:0]          in_z;
    logic [qswg_pkg::GainW-1:0] in_gain;

    // stage 1
    logic [LinNumW-1:0]         s1_lin_num_reg;
    logic [AxNumW-1:0]          s1_ax_num_reg [3];
    logic [SqW-1:0]             s1_sq_reg;
    logic [qswg_pkg::GainW-1:0] s1_gain_reg;

    // stage 2
    logic [LinProdW-1:0]        lin_prod;
    logic [AxProdW-1:0]         ax_prod [3];
    logic [QuotW-1:0]           s2_qlin_reg;
    logic [QuotW-1:0]           s2_qax_reg [3];
    logic [qswg_pkg::RootW-1:0] s2_root_reg;
    logic [qswg_pkg::GainW-1:0] s2_gain_reg;
    logic [qswg_pkg::RootW-1:0] root_rom [SqMax+1];

    // stage 3
    logic signed [17:0] lin_next;
    logic signed [17:0] ax_next [3];
    logic signed [17:0] inv_blend;
    logic signed [17:0] s3_lin_reg;
    logic signed [17:0] s3_az_reg;
    logic [32:0]        s3_rad_prod_reg;
    logic signed [35:0] s3_sep_prod_reg;
    logic signed [35:0] s3_en_a_reg;
    logic [31:0]        s3_en_b_reg;

    // stage 4
    logic [33:0]        rad_round;
    logic signed [37:0] en_sum;
    logic signed [17:0] s4_lin_reg;
    logic signed [17:0] s4_az_reg;
    logic signed [19:0] s4_rad_w_reg;
    logic signed [20:0] s4_sep_t_reg;
    logic signed [22:0] s4_en_w_reg;

    // stage 5
    logic signed [17:0] s5_lin_reg;
    logic signed [19:0] s5_rad_w_reg;
    logic signed [38:0] s5_sep_prod_reg;
    logic signed [22:0] s5_en_w_reg;

    // stage 6
    logic signed [23:0]           sep_w;
    logic signed [39:0]           w_sel;
    logic [qswg_pkg::WeightW-1:0] weight_next;
    logic [qswg_pkg::WeightW-1:0] s6_weight_reg;

    // stage 7
    logic [35:0]                  s7_bw_reg;
    logic [qswg_pkg::WeightW-1:0] s7_weight_reg;

    // stage 8
    logic [33:0]                  s8_plo_reg;
    logic [33:0]                  s8_phi_reg;
    logic [qswg_pkg::WeightW-1:0] s8_weight_reg;

    // stage 9
    logic [51:0]                  step_total;
    logic [52:0]                  step_round;
    logic [25:0]                  step_q;
    logic [qswg_pkg::StepW-1:0]   step_next;
    logic [qswg_pkg::WeightW-1:0] out_weight_reg;
    logic [qswg_pkg::StepW-1:0]   out_step_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= qswg_pkg::ModeReset;
            slope_reg <= qswg_pkg::SlopeReset;
            blend_reg <= qswg_pkg::BlendReset;
            base_reg  <= qswg_pkg::BaseReset;
            scale_reg <= qswg_pkg::ScaleReset;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                qswg_pkg::CfgWeightMode: mode_reg  <= cfg_wdata[qswg_pkg::ModeW-1:0];
                qswg_pkg::CfgSlope:      slope_reg <= cfg_wdata[qswg_pkg::SlopeW-1:0];
                qswg_pkg::CfgBlend:      blend_reg <= cfg_wdata[qswg_pkg::BlendW-1:0];
                qswg_pkg::CfgBaseStep:   base_reg  <= cfg_wdata[qswg_pkg::StepW-1:0];
                qswg_pkg::CfgBlockScale: scale_reg <= cfg_wdata[qswg_pkg::ScaleW-1:0];
                default:                 ;
            endcase
        end
    end

    // per-stage ready, bubbles collapse
    always_comb
    begin
        rdy[NumStages+1] = m_tready;
        for (int k = NumStages; k >= 1; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NumStages; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign in_x    = s_tdata[CoordW-1:0];
    assign in_y    = s_tdata[2*CoordW-1:CoordW];
    assign in_z    = s_tdata[3*CoordW-1:2*CoordW];
    assign in_gain = s_tdata[3*CoordW+qswg_pkg::GainW-1:3*CoordW];

    // stage 1: slope products with rounding offset, squared radius
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_lin_num_reg   <= LinNumW'(slope_reg) *
                                LinNumW'(SumW'(in_x) + SumW'(in_y) + SumW'(in_z)) +
                                LinNumW'(LinDen / 2);
            s1_ax_num_reg[0] <= AxNumW'(slope_reg) * AxNumW'(in_x) + AxNumW'(AxDen / 2);
            s1_ax_num_reg[1] <= AxNumW'(slope_reg) * AxNumW'(in_y) + AxNumW'(AxDen / 2);
            s1_ax_num_reg[2] <= AxNumW'(slope_reg) * AxNumW'(in_z) + AxNumW'(AxDen / 2);
            s1_sq_reg        <= SqW'(in_x) * SqW'(in_x) + SqW'(in_y) * SqW'(in_y) +
                                SqW'(in_z) * SqW'(in_z);
            s1_gain_reg      <= in_gain;
        end
    end

    // radial root table
    for (genvar i = 0; i <= SqMax; i++)
    begin : g_root
        assign root_rom[i] = qswg_pkg::root_entry(i, MaxFreq);
    end

    // stage 2: constant divides by reciprocal multiply, root lookup
    assign lin_prod = LinProdW'(s1_lin_num_reg) * LinProdW'(LinRecip);

    for (genvar a = 0; a < 3; a++)
    begin : g_axdiv
        assign ax_prod[a] = AxProdW'(s1_ax_num_reg[a]) * AxProdW'(AxRecip);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s2_qlin_reg <= lin_prod[LinShift +: QuotW];
            for (int a = 0; a < 3; a++)
            begin
                s2_qax_reg[a] <= ax_prod[a][AxShift +: QuotW];
            end
            s2_root_reg <= root_rom[s1_sq_reg];
            s2_gain_reg <= s1_gain_reg;
        end
    end

    // stage 3: base weights and first products of each mode
    always_comb
    begin
        lin_next = 18'sd32768 - $signed({1'b0, s2_qlin_reg});
        for (int a = 0; a < 3; a++)
        begin
            ax_next[a] = 18'sd32768 - $signed({1'b0, s2_qax_reg[a]});
        end
        inv_blend = 18'sd32768 - $signed({2'b0, blend_reg});
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s3_lin_reg      <= lin_next;
            s3_az_reg       <= ax_next[2];
            s3_rad_prod_reg <= 33'(slope_reg) * 33'(s2_root_reg);
            s3_sep_prod_reg <= 36'(ax_next[0]) * 36'(ax_next[1]);
            s3_en_a_reg     <= 36'(inv_blend) * 36'(lin_next);
            s3_en_b_reg     <= 32'(blend_reg) * 32'(s2_gain_reg);
        end
    end

    // stage 4: rounding back to q1.15
    assign rad_round = 34'(s3_rad_prod_reg) + 34'(qswg_pkg::HalfQ15);
    assign en_sum    = 38'(s3_en_a_reg) + $signed({6'b0, s3_en_b_reg});

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            s4_lin_reg   <= s3_lin_reg;
            s4_az_reg    <= s3_az_reg;
            s4_rad_w_reg <= 20'sd32768 - $signed({1'b0, rad_round[33:15]});
            s4_sep_t_reg <= 21'(qswg_pkg::rdiv_q15(48'(s3_sep_prod_reg)));
            s4_en_w_reg  <= 23'(qswg_pkg::rdiv_q15(48'(en_sum)));
        end
    end

    // stage 5: second separable product
    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            s5_lin_reg      <= s4_lin_reg;
            s5_rad_w_reg    <= s4_rad_w_reg;
            s5_sep_prod_reg <= 39'(s4_sep_t_reg) * 39'(s4_az_reg);
            s5_en_w_reg     <= s4_en_w_reg;
        end
    end

    // stage 6: mode select and weight clamp
    always_comb
    begin
        sep_w = 24'(qswg_pkg::rdiv_q15(48'(s5_sep_prod_reg)));
        unique case (mode_reg)
            qswg_pkg::ModeRadial:    w_sel = 40'(s5_rad_w_reg);
            qswg_pkg::ModeSeparable: w_sel = 40'(sep_w);
            qswg_pkg::ModeEnergy:    w_sel = 40'(s5_en_w_reg);
            default:                 w_sel = 40'(s5_lin_reg);
        endcase
        priority if (w_sel < $signed(40'(qswg_pkg::WeightFloor)))
        begin
            weight_next = qswg_pkg::WeightW'(qswg_pkg::WeightFloor);
        end
        else if (w_sel > $signed(40'(qswg_pkg::WeightCeil)))
        begin
            weight_next = qswg_pkg::WeightW'(qswg_pkg::WeightCeil);
        end
        else
        begin
            weight_next = w_sel[qswg_pkg::WeightW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            s6_weight_reg <= weight_next;
        end
    end

    // stage 7: base step times weight
    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            s7_bw_reg     <= 36'(base_reg) * 36'(s6_weight_reg);
            s7_weight_reg <= s6_weight_reg;
        end
    end

    // stage 8: partial products with the block scale
    always_ff @(posedge clk)
    begin
        if (rdy[8])
        begin
            s8_plo_reg    <= 34'(s7_bw_reg[17:0]) * 34'(scale_reg);
            s8_phi_reg    <= 34'(s7_bw_reg[35:18]) * 34'(scale_reg);
            s8_weight_reg <= s7_weight_reg;
        end
    end

    // stage 9: sum, round and clamp the step
    always_comb
    begin
        step_total = {s8_phi_reg, 18'd0} + 52'(s8_plo_reg);
        step_round = 53'(step_total) + (53'd1 << (qswg_pkg::StepShift - 1));
        step_q     = step_round[52:qswg_pkg::StepShift];
        priority if (step_q < 26'(qswg_pkg::StepFloor))
        begin
            step_next = qswg_pkg::StepW'(qswg_pkg::StepFloor);
        end
        else if (step_q > 26'(qswg_pkg::StepCeil))
        begin
            step_next = qswg_pkg::StepW'(qswg_pkg::StepCeil);
        end
        else
        begin
            step_next = step_q[qswg_pkg::StepW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[9])
        begin
            out_weight_reg <= s8_weight_reg;
            out_step_reg   <= step_next;
        end
    end

    assign m_tvalid = valid_reg[NumStages];
    assign m_tdata  = MDataW'({out_step_reg, out_weight_reg});

`ifndef SYNTH
    a_weight_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_weight_reg >= qswg_pkg::WeightW'(qswg_pkg::WeightFloor))
        else $error("weight below floor on output transfer");

    a_step_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_step_reg >= qswg_pkg::StepW'(qswg_pkg::StepFloor))
        else $error("step below floor on output transfer");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && (&valid_reg)) |-> !s_tready)
        else $error("input accepted while pipeline full and stalled");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[1])
        else $error("accepted transfer lost at first stage");
`endif

endmodule

@@ tb/quant_step_weight_generator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quant_step_weight_generator_core_tb
// self-checking bench for the quantizer step and frequency weight generator:
// a directed table of corner positions and register settings, then random
// positions over several register settings, with random stalls on both
// streams; every result transfer is compared against its table value or a local model
// ----------------------------------------------------------------------------
module quant_step_weight_generator_core_tb;

    localparam longint MaxFreq  = longint'(qswg_pkg::BlockEdgeDefault) - 1;
    localparam longint QOne     = longint'(qswg_pkg::OneQ15);
    localparam longint WMin     = longint'(qswg_pkg::WeightFloor);
    localparam longint WMax     = longint'(qswg_pkg::WeightCeil);
    localparam longint unsigned SMin = longint'(qswg_pkg::StepFloor);
    localparam longint unsigned SMax = longint'(qswg_pkg::StepCeil);

    localparam logic [qswg_pkg::ModeW-1:0] ModeOrder [4] =
        '{qswg_pkg::ModeLinear, qswg_pkg::ModeRadial, qswg_pkg::ModeSeparable,
          qswg_pkg::ModeEnergy};

    typedef struct packed {
        logic [qswg_pkg::WeightW-1:0] weight;
        logic [qswg_pkg::StepW-1:0]   step_size;
    } weight_step_t;

    typedef struct packed {
        bit           given;
        weight_step_t value;
    } known_result_t;

    typedef struct packed {
        logic [qswg_pkg::ModeW-1:0]   mode;
        logic [qswg_pkg::SlopeW-1:0]  slope;
        logic [qswg_pkg::BlendW-1:0]  blend;
        logic [qswg_pkg::StepW-1:0]   base;
        logic [qswg_pkg::ScaleW-1:0]  scale;
        logic [3:0]                   x;
        logic [3:0]                   y;
        logic [3:0]                   z;
        logic [qswg_pkg::GainW-1:0]   gain;
        bit                           known;
        logic [qswg_pkg::WeightW-1:0] w;
        logic [qswg_pkg::StepW-1:0]   s;
    } dir_row_t;

    // mode, slope, blend, base, scale, x, y, z, gain, known, weight, step
    localparam dir_row_t DirectedRows [20] = '{
        '{qswg_pkg::ModeLinear,    16'd19661, 16'd0,     20'd256,     16'd4096,
          4'd0,  4'd0,  4'd0,  16'd0,     1'b1, 16'd32768, 20'd256},
        '{qswg_pkg::ModeLinear,    16'd19661, 16'd0,     20'd256,     16'd4096,
          4'd15, 4'd15, 4'd15, 16'd65535, 1'b1, 16'd13107, 20'd128},
        '{qswg_pkg::ModeLinear,    16'd19661, 16'd0,     20'd256,     16'd4096,
          4'd3,  4'd8,  4'd12, 16'd4660,  1'b0, 16'd0,     20'd0},
        '{qswg_pkg::ModeRadial,    16'd19661, 16'd0,     20'd256,     16'd4096,
          4'd15, 4'd15, 4'd15, 16'd0,     1'b1, 16'd13107, 20'd128},
        '{qswg_pkg::ModeRadial,    16'd19661, 16'd0,     20'd256,     16'd4096,
          4'd1,  4'd2,  4'd3,  16'd0,     1'b0, 16'd0,     20'd0},
        '{qswg_pkg::ModeRadial,    16'd19661, 16'd0,     20'd256,     16'd4096,
          4'd15, 4'd0,  4'd0,  16'd0,     1'b0, 16'd0,     20'd0},
        '{qswg_pkg::ModeSeparable, 16'd19661, 16'd0,     20'd256,     16'd4096,
          4'd15, 4'd15, 4'd15, 16'd0,     1'b0, 16'd0,     20'd0},
        '{qswg_pkg::ModeSeparable, 16'd19661, 16'd0,     20'd256,     16'd4096,
          4'd7,  4'd0,  4'd15, 16'd0,     1'b0, 16'd0,     20'd0},
        '{qswg_pkg::ModeEnergy,    16'd19661, 16'd32768, 20'd256,     16'd4096,
          4'd0,  4'd0,  4'd0,  16'd65535, 1'b1, 16'd65535, 20'd512},
        '{qswg_pkg::ModeEnergy,    16'd19661, 16'd16384, 20'd256,     16'd4096,
          4'd5,  4'd9,  4'd2,  16'd0,     1'b0, 16'd0,     20'd0},
        '{qswg_pkg::ModeEnergy,    16'd19661, 16'd65535, 20'd256,     16'd4096,
          4'd15, 4'd15, 4'd15, 16'd65535, 1'b0, 16'd0,     20'd0},
        '{qswg_pkg::ModeLinear,    16'd65535, 16'd0,     20'd256,     16'd4096,
          4'd15, 4'd15, 4'd15, 16'd0,     1'b1, 16'd1638,  20'd128},
        '{qswg_pkg::ModeLinear,    16'd19661, 16'd0,     20'd1048575, 16'd65535,
          4'd0,  4'd0,  4'd0,  16'd0,     1'b1, 16'd32768, 20'd1048575},
        '{qswg_pkg::ModeLinear,    16'd19661, 16'd0,     20'd0,       16'd4096,
          4'd0,  4'd0,  4'd0,  16'd0,     1'b1, 16'd32768, 20'd128},
        '{qswg_pkg::ModeLinear,    16'd19661, 16'd0,     20'd256,     16'd0,
          4'd0,  4'd0,  4'd0,  16'd0,     1'b1, 16'd32768, 20'd128},
        '{qswg_pkg::ModeRadial,    16'd0,     16'd0,     20'd256,     16'd4096,
          4'd15, 4'd15, 4'd15, 16'd0,     1'b1, 16'd32768, 20'd256},
        '{qswg_pkg::ModeSeparable, 16'd65535, 16'd0,     20'd256,     16'd4096,
          4'd15, 4'd0,  4'd0,  16'd0,     1'b0, 16'd0,     20'd0},
        '{qswg_pkg::ModeRadial,    16'd32768, 16'd0,     20'd256,     16'd4096,
          4'd15, 4'd15, 4'd15, 16'd0,     1'b1, 16'd1638,  20'd128},
        '{qswg_pkg::ModeEnergy,    16'd0,     16'd65535, 20'd1048575, 16'd65535,
          4'd9,  4'd6,  4'd3,  16'd40000, 1'b0, 16'd0,     20'd0},
        '{qswg_pkg::ModeSeparable, 16'd32768, 16'd0,     20'd1000,    16'd5000,
          4'd8,  4'd4,  4'd2,  16'd12345, 1'b0, 16'd0,     20'd0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [qswg_pkg::CfgAddrW-1:0] cfg_addr = '0;
    logic [qswg_pkg::CfgDataW-1:0] cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [31:0]                   s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [39:0]                   m_tdata;

    logic [qswg_pkg::ModeW-1:0]  mode_setting  = qswg_pkg::ModeReset;
    logic [qswg_pkg::SlopeW-1:0] slope_setting = qswg_pkg::SlopeReset;
    logic [qswg_pkg::BlendW-1:0] blend_setting = qswg_pkg::BlendReset;
    logic [qswg_pkg::StepW-1:0]  base_setting  = qswg_pkg::BaseReset;
    logic [qswg_pkg::ScaleW-1:0] scale_setting = qswg_pkg::ScaleReset;

    weight_step_t  expected_steps [$];
    known_result_t given_results [$];
    int unsigned   fail_count = 0;
    int unsigned   results_seen = 0;
    bit            sender_idle = 1'b0;
    bit            receiver_idle = 1'b0;
    bit            hold_active = 1'b0;
    bit            hold_done = 1'b0;

    quant_step_weight_generator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("quant_step_weight_generator_core_tb: errors");
        $finish;
    end

    function automatic longint round_half_away(input longint num, input longint den);
        if (num >= 0)
        begin
            return (num + den / 2) / den;
        end
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint floor_root(input longint v);
        longint r;
        longint c;
        r = 0;
        for (int b = 17; b >= 0; b--)
        begin
            c = r + (longint'(1) << b);
            if (c * c <= v)
            begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic weight_step_t weight_and_step(input logic [3:0] fx,
                                                     input logic [3:0] fy,
                                                     input logic [3:0] fz,
                                                     input logic [qswg_pkg::GainW-1:0] gain);
        longint x;
        longint y;
        longint z;
        longint sl;
        longint bl;
        longint lin;
        longint w;
        longint ax;
        longint ay;
        longint az;
        longint r;
        longint unsigned prod;
        longint unsigned stp;
        weight_step_t res;
        x   = longint'(fx);
        y   = longint'(fy);
        z   = longint'(fz);
        sl  = longint'(slope_setting);
        bl  = longint'(blend_setting);
        lin = QOne - round_half_away(sl * (x + y + z), 3 * MaxFreq);
        case (mode_setting)
            qswg_pkg::ModeRadial:
            begin
                r = floor_root(((x * x + y * y + z * z) << 30) / (3 * MaxFreq * MaxFreq));
                w = QOne - round_half_away(sl * r, QOne);
            end
            qswg_pkg::ModeSeparable:
            begin
                ax = QOne - round_half_away(sl * x, MaxFreq);
                ay = QOne - round_half_away(sl * y, MaxFreq);
                az = QOne - round_half_away(sl * z, MaxFreq);
                w  = round_half_away(round_half_away(ax * ay, QOne) * az, QOne);
            end
            qswg_pkg::ModeEnergy:
            begin
                w = round_half_away((QOne - bl) * lin + bl * longint'(gain), QOne);
            end
            default:
            begin
                w = lin;
            end
        endcase
        if (w < WMin)
        begin
            w = WMin;
        end
        if (w > WMax)
        begin
            w = WMax;
        end
        prod = longint'(base_setting) * longint'(w) * longint'(scale_setting);
        stp  = (prod + (64'd1 << 26)) >> qswg_pkg::StepShift;
        if (stp < SMin)
        begin
            stp = SMin;
        end
        if (stp > SMax)
        begin
            stp = SMax;
        end
        res.weight    = w[qswg_pkg::WeightW-1:0];
        res.step_size = stp[qswg_pkg::StepW-1:0];
        return res;
    endfunction

    function automatic int unsigned pick_value(input int unsigned typical,
                                               input int unsigned top);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return top;
            2: return typical;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    task automatic write_reg(input logic [qswg_pkg::CfgAddrW-1:0] addr,
                             input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val[qswg_pkg::CfgDataW-1:0];
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [qswg_pkg::ModeW-1:0] mode,
                                 input int unsigned sl,
                                 input int unsigned bl, input int unsigned base,
                                 input int unsigned scale);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_steps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
        write_reg(qswg_pkg::CfgWeightMode, 32'(mode));
        write_reg(qswg_pkg::CfgSlope, sl);
        write_reg(qswg_pkg::CfgBlend, bl);
        write_reg(qswg_pkg::CfgBaseStep, base);
        write_reg(qswg_pkg::CfgBlockScale, scale);
        cfg_wr_en     <= 1'b0;
        mode_setting  = mode;
        slope_setting = sl[qswg_pkg::SlopeW-1:0];
        blend_setting = bl[qswg_pkg::BlendW-1:0];
        base_setting  = base[qswg_pkg::StepW-1:0];
        scale_setting = scale[qswg_pkg::ScaleW-1:0];
    endtask

    task automatic send_position(input logic [3:0] x, input logic [3:0] y,
                                 input logic [3:0] z,
                                 input logic [qswg_pkg::GainW-1:0] gain,
                                 input bit given, input weight_step_t value);
        if (sender_idle && !hold_active && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        given_results.push_back('{given, value});
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, gain, z, y, x};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // sink side: random stalls plus one long hold-off to back up the pipe
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!hold_done && results_seen >= 400)
            begin
                hold_active = 1'b1;
                m_tready <= 1'b0;
                repeat (120) @(posedge clk);
                m_tready <= 1'b1;
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end
            else if (receiver_idle && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : scoreboard
        known_result_t tag;
        weight_step_t  want;
        weight_step_t  got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                tag = given_results.pop_front();
                if (tag.given)
                begin
                    expected_steps.push_back(tag.value);
                end
                else
                begin
                    expected_steps.push_back(weight_and_step(s_tdata[3:0], s_tdata[7:4],
                                                             s_tdata[11:8], s_tdata[27:12]));
                end
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got.weight    = m_tdata[15:0];
                got.step_size = m_tdata[35:16];
                if (expected_steps.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected transfer: expected none, actual weight %0d step %0d",
                             $time, got.weight, got.step_size);
                end
                else
                begin
                    want = expected_steps.pop_front();
                    if (got.weight !== want.weight)
                    begin
                        fail_count++;
                        $display("%0t weight mismatch: expected %0d actual %0d",
                                 $time, want.weight, got.weight);
                    end
                    if (got.step_size !== want.step_size)
                    begin
                        fail_count++;
                        $display("%0t step_size mismatch: expected %0d actual %0d",
                                 $time, want.step_size, got.step_size);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t row;
        logic [qswg_pkg::GainW-1:0] gain;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;

        for (int i = 0; i < 20; i++)
        begin
            row = DirectedRows[i];
            if ({row.mode, row.slope, row.blend, row.base, row.scale} !==
                {mode_setting, slope_setting, blend_setting, base_setting, scale_setting})
            begin
                load_settings(row.mode, 32'(row.slope), 32'(row.blend),
                              32'(row.base), 32'(row.scale));
            end
            send_position(row.x, row.y, row.z, row.gain, row.known, {row.w, row.s});
        end

        for (int phase = 0; phase < 10; phase++)
        begin
            load_settings(ModeOrder[phase % 4], pick_value(19661, 65535),
                          pick_value(32768, 65535), pick_value(256, 1048575),
                          pick_value(4096, 65535));
            sender_idle   = (phase < 8) && (phase != 3);
            receiver_idle = (phase < 8) && (phase != 2);
            repeat (70)
            begin
                case ($urandom_range(0, 3))
                    0: gain = 16'd32768;
                    1: gain = 16'($urandom_range(0, 32768));
                    default: gain = 16'($urandom_range(0, 65535));
                endcase
                send_position(($urandom_range(0, 7) == 0) ? 4'd15 : 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)),
                              ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(0, 15)),
                              gain, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_steps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("quant_step_weight_generator_core_tb: clean");
        end
        else
        begin
            $display("quant_step_weight_generator_core_tb: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/qswg_pkg.sv
src/quant_step_weight_generator_core.sv
tb/quant_step_weight_generator_core_tb.sv
